[src/dpc_pkg.sv]
// ----------------------------------------------------------------------------
// dpc_pkg
// shared types and constants of the dual period capture block
// ----------------------------------------------------------------------------
package dpc_pkg;

    localparam int unsigned STAMP_W   = 16;
    localparam int unsigned COUNT_W   = 16;
    localparam int unsigned PERIOD_W  = 32;
    localparam int unsigned EDGE_W    = 8;
    localparam int unsigned CFG_W     = 16;
    localparam int unsigned S_DATA_W  = 16;
    localparam int unsigned S_USER_W  = 2;
    localparam int unsigned M_DATA_W  = 72;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [EDGE_W-1:0]  ODO_DIVIDER_RST = 8'd3;
    localparam logic [COUNT_W-1:0] TIMEOUT_RST     = 16'd3;

    // configuration register indexes
    typedef enum logic {
        REG_ODO_DIVIDER = 1'b0,
        REG_TIMEOUT     = 1'b1
    } cfg_reg_t;

    // event codes
    typedef enum logic [1:0] {
        EV_SPEED    = 2'd0,
        EV_TACH     = 2'd1,
        EV_OVERFLOW = 2'd2,
        EV_ODO_ACK  = 2'd3
    } event_kind_t;

    typedef struct packed {
        logic capture;
        logic overflow;
    } chan_ctrl_t;

    typedef struct packed {
        logic speed_edge;
        logic ack;
    } odo_ctrl_t;

endpackage

[src/dpc_channel.sv]
// ----------------------------------------------------------------------------
// dpc_channel
// one capture channel: phase, first stamp, overflow count and period
// ----------------------------------------------------------------------------
module dpc_channel (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  dpc_pkg::chan_ctrl_t            ctrl,
    input  logic [dpc_pkg::STAMP_W-1:0]    stamp,
    input  logic [dpc_pkg::COUNT_W-1:0]    timeout,
    output logic [dpc_pkg::PERIOD_W-1:0]   period_next
);
    import dpc_pkg::*;

    logic                phase_reg, phase_next;
    logic [STAMP_W-1:0]  first_reg, first_next;
    logic [COUNT_W-1:0]  ovf_reg, ovf_next;
    logic [COUNT_W-1:0]  ovf_inc;
    logic [PERIOD_W-1:0] period_reg;

    always_comb begin
        phase_next  = phase_reg;
        first_next  = first_reg;
        ovf_next    = ovf_reg;
        period_next = period_reg;
        ovf_inc     = (ovf_reg != COUNT_MAX) ? ovf_reg + 1'b1 : ovf_reg;
        if (ctrl.capture) begin
            ovf_next = '0;
            if (!phase_reg) begin
                first_next = stamp;
                phase_next = 1'b1;
            end else begin
                // overflow count supplies the upper half of the elapsed time
                period_next = {ovf_reg, stamp} - {{(PERIOD_W-STAMP_W){1'b0}}, first_reg};
                phase_next  = 1'b0;
            end
        end else if (ctrl.overflow) begin
            if (ovf_inc > timeout) begin
                ovf_next    = '0;
                period_next = '0;
                phase_next  = 1'b0;
            end else begin
                ovf_next = ovf_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= 1'b0;
            first_reg  <= '0;
            ovf_reg    <= '0;
            period_reg <= '0;
        end else begin
            phase_reg  <= phase_next;
            first_reg  <= first_next;
            ovf_reg    <= ovf_next;
            period_reg <= period_next;
        end
    end

endmodule

[src/dpc_odo.sv]
// ----------------------------------------------------------------------------
// dpc_odo
// speed edge divider and odometer pending flag
// ----------------------------------------------------------------------------
module dpc_odo (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  dpc_pkg::odo_ctrl_t           ctrl,
    input  logic [dpc_pkg::EDGE_W-1:0]   divider,
    output logic                         flag_next
);
    import dpc_pkg::*;

    logic              flag_reg;
    logic [EDGE_W-1:0] edge_reg, edge_next;
    logic [EDGE_W-1:0] edge_inc;

    always_comb begin
        edge_next = edge_reg;
        flag_next = flag_reg;
        edge_inc  = edge_reg + 1'b1;
        if (ctrl.speed_edge && !flag_reg) begin
            // divider holds while a tick is pending
            if (edge_inc >= divider) begin
                edge_next = '0;
                flag_next = 1'b1;
            end else begin
                edge_next = edge_inc;
            end
        end else if (ctrl.ack) begin
            flag_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flag_reg <= 1'b0;
            edge_reg <= '0;
        end else begin
            flag_reg <= flag_next;
            edge_reg <= edge_next;
        end
    end

endmodule

[src/dual_period_capture_with_timeout_top.sv]
// ----------------------------------------------------------------------------
// dual_period_capture_with_timeout_top
// two-channel period meter on a shared 16-bit timer with overflow timeout
// ----------------------------------------------------------------------------
// Each request on the slave side is one event: a speed capture, a tach
// capture, a timer overflow or an odometer acknowledge. Every event yields
// exactly one result holding both channel periods and the odometer pending
// flag as they stand after that event. A capture alternately stores a first
// timestamp or closes a period of {overflows, stamp} - first ticks, mod 2^32.
// Overflow events count per channel; a count above timeout_overflows zeroes
// that channel's period. A speed edge, unless a tick is pending, advances a
// divider that raises odo_pending after odo_divider edges; an acknowledge
// clears it. The block takes one event per clock unless a result stalls: an
// input register feeds a single pass of update logic into the result
// register, and the output register lets a new event enter while a result
// waits. The user must write configuration only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module dual_period_capture_with_timeout_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration write port
    input  logic                          cfg_wr_en,
    input  logic                          cfg_addr,
    input  logic [dpc_pkg::CFG_W-1:0]     cfg_wdata,
    // event requests
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [dpc_pkg::S_DATA_W-1:0]  s_tdata,   // [15:0] capture_value
    input  logic [dpc_pkg::S_USER_W-1:0]  s_tuser,   // [1:0] event_kind
    // results
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [dpc_pkg::M_DATA_W-1:0]  m_tdata    // [31:0] speed_period,
                                                     // [63:32] tach_period,
                                                     // [64] odo_pending, rest zero
);
    import dpc_pkg::*;

    // configuration registers
    logic [EDGE_W-1:0]   odo_divider_reg;
    logic [COUNT_W-1:0]  timeout_reg;

    // input register
    logic                in_valid_reg;
    event_kind_t         kind_reg;
    logic [STAMP_W-1:0]  stamp_reg;

    // result register
    logic                out_valid_reg;
    logic [M_DATA_W-1:0] out_data_reg;

    logic                advance;
    chan_ctrl_t          speed_ctrl, tach_ctrl;
    odo_ctrl_t           odo_ctrl;
    logic [PERIOD_W-1:0] speed_period_next, tach_period_next;
    logic                odo_flag_next;

    // the update stage fires when its item can land in the result register
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            odo_divider_reg <= ODO_DIVIDER_RST;
            timeout_reg     <= TIMEOUT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_ODO_DIVIDER: odo_divider_reg <= cfg_wdata[EDGE_W-1:0];
                REG_TIMEOUT:     timeout_reg     <= cfg_wdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            kind_reg  <= event_kind_t'(s_tuser);
            stamp_reg <= s_tdata[STAMP_W-1:0];
        end
    end

    // event decode, gated by the update strobe
    always_comb begin
        speed_ctrl = '0;
        tach_ctrl  = '0;
        odo_ctrl   = '0;
        if (advance) begin
            unique case (kind_reg)
                EV_SPEED: begin
                    speed_ctrl.capture  = 1'b1;
                    odo_ctrl.speed_edge = 1'b1;
                end
                EV_TACH: begin
                    tach_ctrl.capture = 1'b1;
                end
                EV_OVERFLOW: begin
                    // the timer is shared, so both channels see the overflow
                    speed_ctrl.overflow = 1'b1;
                    tach_ctrl.overflow  = 1'b1;
                end
                EV_ODO_ACK: begin
                    odo_ctrl.ack = 1'b1;
                end
                default: ;
            endcase
        end
    end

    dpc_channel u_speed (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (speed_ctrl),
        .stamp       (stamp_reg),
        .timeout     (timeout_reg),
        .period_next (speed_period_next)
    );

    dpc_channel u_tach (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (tach_ctrl),
        .stamp       (stamp_reg),
        .timeout     (timeout_reg),
        .period_next (tach_period_next)
    );

    dpc_odo u_odo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (odo_ctrl),
        .divider   (odo_divider_reg),
        .flag_next (odo_flag_next)
    );

    // result register: snapshot of state after the event
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= {{(M_DATA_W-2*PERIOD_W-1){1'b0}}, odo_flag_next,
                             tach_period_next, speed_period_next};
        end
    end

    // an acknowledge always reports the flag cleared
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && kind_reg == EV_ODO_ACK) |=> !m_tdata[2*PERIOD_W])
        else $error("odo_pending set after acknowledge");

    // a result appears only from the update stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(advance))
        else $error("result without an update");

    // an empty input register always takes a request
    assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_tready)
        else $error("input stalled while empty");

    // a stalled result blocks the update stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |-> !advance)
        else $error("update overwrote a pending result");

endmodule

[tb/sv/dual_period_capture_with_timeout_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dual_period_capture_with_timeout_top_tb
// self-checking bench for the two-channel period meter
// ----------------------------------------------------------------------------
// Event requests are queued by the stimulus process and driven by a clocked
// driver. Each accepted request runs through a behavioral copy of the meter,
// and the result it yields is queued. A clocked monitor compares every
// result, field by field, with the oldest queued one. Directed cases cover
// stamp extremes, wrap, timeouts and odometer corner cases. Random phases run
// under several register settings and traffic patterns, plus one long
// receiver hold-off and overflow runs under the largest timeout settings.
// ----------------------------------------------------------------------------
module dual_period_capture_with_timeout_top_tb;
    import dpc_pkg::*;

    localparam int CLK_HALF_NS      = 2;
    localparam int RESET_CYCLES     = 9;
    localparam int SETTLE_CYCLES    = 8;
    localparam int HOLD_CYCLES      = 300;
    localparam int RANDOM_PER_PHASE = 190;
    localparam int PRESSURE_ITEMS   = 100;
    localparam int LIMIT_NS         = 3_000_000;

    localparam int CH_SPEED = 0;
    localparam int CH_TACH  = 1;

    // result as laid out in m_tdata, speed period in the lowest bits
    typedef struct packed {
        logic                odo_pending;
        logic [PERIOD_W-1:0] tach_period;
        logic [PERIOD_W-1:0] speed_period;
    } meter_result_t;

    typedef struct packed {
        event_kind_t        kind;
        logic [STAMP_W-1:0] stamp;
    } meter_event_t;

    typedef enum logic [1:0] {
        MODE_FREE,
        MODE_TX_IDLE,
        MODE_RX_STALL,
        MODE_BOTH
    } traffic_mode_t;

    localparam int RES_W = $bits(meter_result_t);

    // dut signals; the inputs are known from time zero
    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic                cfg_addr  = 1'b0;
    logic [CFG_W-1:0]    cfg_wdata = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata   = '0;   // [15:0] capture_value
    logic [S_USER_W-1:0] s_tuser   = '0;   // [1:0] event_kind
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;          // [31:0] speed, [63:32] tach, [64] odo

    // behavioral copy of the meter state and its registers
    logic                armed       [2];
    logic [STAMP_W-1:0]  start_stamp [2];
    logic [COUNT_W-1:0]  ovf_cnt     [2];
    logic [PERIOD_W-1:0] meas_period [2];
    logic [EDGE_W-1:0]   odo_edges;
    logic                odo_pend;
    logic [EDGE_W-1:0]   cfg_divider = ODO_DIVIDER_RST;
    logic [COUNT_W-1:0]  cfg_timeout = TIMEOUT_RST;

    meter_event_t  pending_events[$];
    meter_result_t expected_results[$];
    meter_event_t  next_event;
    meter_result_t seen_result;
    meter_result_t oldest_result;

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    bit hold_req     = 1'b0;
    bit rx_hold      = 1'b0;

    int n_queued   = 0;
    int n_events   = 0;
    int n_results  = 0;
    int n_errors   = 0;
    int n_settings = 0;
    int n_ticks    = 0;
    int n_timeouts = 0;

    dual_period_capture_with_timeout_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        forever #(CLK_HALF_NS) aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // meter prediction
    // ------------------------------------------------------------------------

    function automatic void clear_meter_model();
        for (int ch = 0; ch < 2; ch++) begin
            armed[ch]       = 1'b0;
            start_stamp[ch] = '0;
            ovf_cnt[ch]     = '0;
            meas_period[ch] = '0;
        end
        odo_edges = '0;
        odo_pend  = 1'b0;
    endfunction

    // an edge arms an unarmed channel and closes the period of an armed one
    function automatic void capture_stamp(int ch, logic [STAMP_W-1:0] stamp);
        if (!armed[ch]) begin
            start_stamp[ch] = stamp;
            ovf_cnt[ch]     = '0;
            armed[ch]       = 1'b1;
        end else begin
            // {overflows, stamp} - first, wrapping at 32 bits
            meas_period[ch] = {ovf_cnt[ch], stamp}
                              - {{(PERIOD_W-STAMP_W){1'b0}}, start_stamp[ch]};
            armed[ch]       = 1'b0;
            ovf_cnt[ch]     = '0;
        end
    endfunction

    // count saturates, so a timeout of all ones never fires
    function automatic void count_overflow(int ch);
        if (ovf_cnt[ch] != COUNT_MAX)
            ovf_cnt[ch] = ovf_cnt[ch] + 1'b1;
        if (ovf_cnt[ch] > cfg_timeout) begin
            ovf_cnt[ch]     = '0;
            meas_period[ch] = '0;
            armed[ch]       = 1'b0;
            n_timeouts++;
        end
    endfunction

    function automatic meter_result_t predict_event(event_kind_t kind,
                                                    logic [STAMP_W-1:0] stamp);
        meter_result_t res;
        case (kind)
            EV_SPEED: begin
                capture_stamp(CH_SPEED, stamp);
                // divider holds while a tick waits for its acknowledge
                if (!odo_pend) begin
                    odo_edges = odo_edges + 1'b1;
                    if (odo_edges >= cfg_divider) begin
                        odo_edges = '0;
                        odo_pend  = 1'b1;
                        n_ticks++;
                    end
                end
            end
            EV_TACH: begin
                capture_stamp(CH_TACH, stamp);
            end
            EV_OVERFLOW: begin
                count_overflow(CH_SPEED);
                count_overflow(CH_TACH);
            end
            default: begin
                odo_pend = 1'b0;
            end
        endcase
        res.speed_period = meas_period[CH_SPEED];
        res.tach_period  = meas_period[CH_TACH];
        res.odo_pending  = odo_pend;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // request driver: offers the oldest pending event, idles at random
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (pending_events.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                next_event = pending_events.pop_front();
                s_tvalid   <= 1'b1;
                s_tdata    <= next_event.stamp;
                s_tuser    <= next_event.kind;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // every accepted request updates the meter copy and queues its result
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            expected_results.push_back(predict_event(event_kind_t'(s_tuser), s_tdata));
            n_events++;
        end
    end

    // receiver: random stalls, forced low during the hold-off
    always @(posedge aclk) begin
        if (!aresetn || rx_hold) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // long receiver hold-off, counted here so the sender keeps going meanwhile
    initial begin
        wait (hold_req);
        @(posedge aclk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        rx_hold <= 1'b0;
    end

    // ------------------------------------------------------------------------
    // result monitor
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen_result = meter_result_t'(m_tdata[RES_W-1:0]);
            n_results++;
            if (expected_results.size() == 0) begin
                $error("result with none expected: m_tdata %h", m_tdata);
                n_errors++;
            end else begin
                oldest_result = expected_results.pop_front();
                if (seen_result.speed_period !== oldest_result.speed_period) begin
                    $error("speed_period: expected %0h, got %0h",
                           oldest_result.speed_period, seen_result.speed_period);
                    n_errors++;
                end
                if (seen_result.tach_period !== oldest_result.tach_period) begin
                    $error("tach_period: expected %0h, got %0h",
                           oldest_result.tach_period, seen_result.tach_period);
                    n_errors++;
                end
                if (seen_result.odo_pending !== oldest_result.odo_pending) begin
                    $error("odo_pending: expected %0b, got %0b",
                           oldest_result.odo_pending, seen_result.odo_pending);
                    n_errors++;
                end
                // upper padding of m_tdata must stay zero
                if (m_tdata[M_DATA_W-1:RES_W] !== '0) begin
                    $error("m_tdata padding: expected 0, got %0h",
                           m_tdata[M_DATA_W-1:RES_W]);
                    n_errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    function automatic void push_event(event_kind_t kind, logic [STAMP_W-1:0] stamp);
        meter_event_t ev;
        ev.kind  = kind;
        ev.stamp = stamp;
        pending_events.push_back(ev);
        n_queued++;
    endfunction

    // captures and overflows dominate so periods close and time out often
    function automatic void push_random(int count);
        int unsigned pick;
        int unsigned stamp_pick;
        logic [STAMP_W-1:0] stamp;
        event_kind_t kind;
        for (int i = 0; i < count; i++) begin
            pick       = $urandom_range(99);
            stamp_pick = $urandom_range(9);
            if (pick < 30)
                kind = EV_SPEED;
            else if (pick < 60)
                kind = EV_TACH;
            else if (pick < 85)
                kind = EV_OVERFLOW;
            else
                kind = EV_ODO_ACK;
            if (stamp_pick == 0)
                stamp = '0;
            else if (stamp_pick == 1)
                stamp = '1;
            else
                stamp = STAMP_W'($urandom_range(65535));
            push_event(kind, stamp);
        end
    endfunction

    function automatic void push_overflows(int count);
        for (int i = 0; i < count; i++)
            push_event(EV_OVERFLOW, STAMP_W'($urandom_range(65535)));
    endfunction

    // wait until every queued request is in and every result has been checked
    task automatic wait_drained();
        do
            @(posedge aclk);
        while (n_events != n_queued || expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // only called while the block is idle
    task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_ODO_DIVIDER: cfg_divider = value[EDGE_W-1:0];
            default:         cfg_timeout = value[COUNT_W-1:0];
        endcase
        n_settings++;
    endtask

    task automatic set_traffic(traffic_mode_t mode);
        @(posedge aclk);
        case (mode)
            MODE_FREE:     begin tx_idle_pct <= 0;  rx_stall_pct <= 0;  end
            MODE_TX_IDLE:  begin tx_idle_pct <= 55; rx_stall_pct <= 0;  end
            MODE_RX_STALL: begin tx_idle_pct <= 0;  rx_stall_pct <= 55; end
            default:       begin tx_idle_pct <= 7;  rx_stall_pct <= 7;  end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial begin
        int unsigned div_val;
        int unsigned tmo_val;

        clear_meter_model();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        set_traffic(MODE_FREE);

        // directed, reset settings (divider 3, timeout 3)
        push_event(EV_SPEED, 16'h0000);      // arm at stamp zero
        push_event(EV_OVERFLOW, 16'h0000);
        push_event(EV_SPEED, 16'hFFFF);      // longest period with one overflow
        push_event(EV_TACH, 16'hFFFF);
        push_event(EV_TACH, 16'h0000);       // second below first: wraps
        push_event(EV_ODO_ACK, 16'hFFFF);    // acknowledge with nothing pending
        push_event(EV_SPEED, 16'h1234);      // edge count reaches the divider: raises the tick
        push_event(EV_SPEED, 16'h8000);      // measured, but divider held
        push_event(EV_ODO_ACK, 16'h0000);
        push_event(EV_TACH, 16'h5555);
        push_overflows(4);                   // both time out, speed unarmed
        wait_drained();

        // divider zero: every counted edge ticks; timeout zero: first overflow
        write_reg(REG_ODO_DIVIDER, 16'd0);
        write_reg(REG_TIMEOUT, 16'd0);
        push_event(EV_SPEED, 16'hAAAA);
        push_event(EV_ODO_ACK, 16'h5555);
        push_event(EV_SPEED, 16'h5555);
        push_event(EV_TACH, 16'hAAAA);
        push_event(EV_OVERFLOW, 16'h0F0F);
        wait_drained();

        // divider raised, edges counted, then lowered below the edge count already reached
        write_reg(REG_ODO_DIVIDER, 16'd200);
        push_event(EV_ODO_ACK, 16'h0000);
        for (int i = 0; i < 4; i++)
            push_event(EV_SPEED, STAMP_W'($urandom_range(65535)));
        wait_drained();
        write_reg(REG_ODO_DIVIDER, 16'd2);
        push_event(EV_SPEED, 16'h00FF);
        wait_drained();

        // random phases, one register setting and traffic pattern each
        for (int p = 0; p < 8; p++) begin
            case (p)
                0:       begin div_val = 1;   tmo_val = 0;     end
                1:       begin div_val = 255; tmo_val = 65534; end
                2:       begin div_val = 3;   tmo_val = 3;     end
                4:       begin div_val = 2;   tmo_val = 1;     end
                5:       begin
                    div_val = $urandom_range(1, 255);
                    tmo_val = $urandom_range(65534);
                end
                default: begin
                    div_val = $urandom_range(1, 16);
                    tmo_val = $urandom_range(8);
                end
            endcase
            write_reg(REG_ODO_DIVIDER, CFG_W'(div_val));
            write_reg(REG_TIMEOUT, CFG_W'(tmo_val));
            set_traffic(traffic_mode_t'(p % 4));
            push_random(RANDOM_PER_PHASE);
            wait_drained();
        end

        // receiver holds off while the sender keeps offering requests
        set_traffic(MODE_FREE);
        hold_req = 1'b1;
        push_random(PRESSURE_ITEMS);
        wait_drained();

        // timeout of all ones: an overflow run never times out a channel
        write_reg(REG_TIMEOUT, 16'hFFFF);
        push_event(EV_SPEED, STAMP_W'($urandom_range(65535)));
        push_event(EV_TACH, STAMP_W'($urandom_range(65535)));
        push_overflows(20);
        push_event(EV_SPEED, STAMP_W'($urandom_range(65535)));
        push_event(EV_TACH, STAMP_W'($urandom_range(65535)));
        wait_drained();

        // largest real timeout: overflow run leaves both channels armed
        write_reg(REG_TIMEOUT, 16'd65534);
        push_event(EV_SPEED, STAMP_W'($urandom_range(65535)));
        push_event(EV_TACH, STAMP_W'($urandom_range(65535)));
        push_overflows(20);
        push_random(20);
        wait_drained();

        if (expected_results.size() != 0) begin
            $error("%0d results never arrived", expected_results.size());
            n_errors++;
        end

        $display("checked %0d results for %0d event requests over %0d register writes",
                 n_results, n_events, n_settings);
        $display("odometer ticks raised %0d, channel timeouts %0d", n_ticks, n_timeouts);
        if (n_errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(LIMIT_NS);
        $display("simulation failed");
        $finish;
    end

endmodule
